// File: rtl/dos_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dos_pkg
// Shared types and codes for the daily on/off schedule table.
// ----------------------------------------------------------------------------
package dos_pkg;

    // input request kinds (s_tuser)
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // entry kinds
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_ONE   = 2'd1;
    localparam logic [1:0] KIND_ALL   = 2'd2;

    // time references
    localparam logic [2:0] REF_UTC   = 3'd0;
    localparam logic [2:0] REF_LOCAL = 3'd1;
    localparam logic [2:0] REF_RISE  = 3'd2;
    localparam logic [2:0] REF_SET   = 3'd3;

    // configuration register indexes
    localparam logic CFG_STD_OFFSET = 1'b0;
    localparam logic CFG_DST_OFFSET = 1'b1;

    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 16;
    localparam logic [10:0] MINUTE_NONE = 11'd2047;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         room;
        logic [2:0]         on_ref;
        logic signed [11:0] on_ofs;
        logic [2:0]         off_ref;
        logic signed [11:0] off_ofs;
    } entry_t;

    // per-tick context, latched when a tick for a new minute is taken
    typedef struct packed {
        logic [10:0]        now;
        logic signed [10:0] loc_ofs;   // selected hour offset times 60
        logic [10:0]        rise;
        logic [10:0]        sun_set;
    } tick_ctx_t;

    typedef struct packed {
        logic [3:0] entry_number;
        logic       switch_on;
        logic       all_rooms;
        logic [7:0] target_room;
    } res_t;

    typedef struct packed {
        logic ready;
        logic pend_vld;
    } q_status_t;

    typedef struct packed {
        logic busy;
    } scan_status_t;

endpackage
`default_nettype wire

// File: rtl/dos_entry_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dos_entry_mem
// Schedule entry store: one write port, one registered read port, with a
// valid bit per entry so that unwritten entries read as empty.
// ----------------------------------------------------------------------------
module dos_entry_mem #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  wr_en,
    input  wire [AW-1:0]         wr_addr,
    input  dos_pkg::entry_t      wr_data,
    input  wire                  rd_en,
    input  wire [AW-1:0]         rd_addr,
    output dos_pkg::entry_t      rd_data,
    output logic                 rd_valid
);

    dos_pkg::entry_t    mem_reg [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    dos_pkg::entry_t    rdata_reg;
    logic               rvld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvld_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rdata_reg;
    assign rd_valid = rvld_reg;

endmodule
`default_nettype wire

// File: rtl/dos_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dos_scan
// Entry walker: issues one read per cycle unless held for queue space;
// converts on/off times to UTC, folds the duration, flags entries firing this minute.
// ----------------------------------------------------------------------------
module dos_scan #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4,
    parameter int CW      = 5
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     start,
    input  dos_pkg::tick_ctx_t      ctx,
    output logic                    rd_en,
    output logic [AW-1:0]           rd_addr,
    input  dos_pkg::entry_t         rd_entry,
    input  wire                     rd_valid,
    input  dos_pkg::q_status_t      q_st,
    output logic                    push,
    output dos_pkg::res_t           res,
    output dos_pkg::scan_status_t   st
);

    function automatic logic signed [12:0] to_utc(
        input logic [2:0]         ref_code,
        input logic signed [11:0] mins,
        input logic signed [10:0] loc_ofs,
        input logic [10:0]        rise,
        input logic [10:0]        sun_set
    );
        logic signed [12:0] m;
        logic signed [12:0] r;
        begin
            m = {mins[11], mins};
            r = m - {{2{loc_ofs[10]}}, loc_ofs};
            case (ref_code)
                dos_pkg::REF_UTC: to_utc = m;
                dos_pkg::REF_LOCAL: begin
                    to_utc = (r < 0) ? r + 13'sd1440 : r;
                end
                dos_pkg::REF_RISE: to_utc = m + $signed({2'b00, rise});
                dos_pkg::REF_SET:  to_utc = m + $signed({2'b00, sun_set});
                default:           to_utc = -13'sd1;
            endcase
        end
    endfunction

    logic            run_reg;
    logic [CW-1:0]   cnt_reg;
    logic            s1_vld_reg;
    logic [AW-1:0]   s1_idx_reg;
    logic            s2_vld_reg;
    logic [AW-1:0]   s2_idx_reg;
    logic            s2_act_reg;
    logic            s2_all_reg;
    logic [7:0]      s2_room_reg;
    logic signed [12:0] s2_on_reg;
    logic signed [12:0] s2_off_reg;
    logic            s3_vld_reg;
    logic            s3_fire_reg;
    dos_pkg::res_t   s3_res_reg;

    logic            adv;
    logic            issue;
    logic            act_next;
    logic signed [12:0] on_next;
    logic signed [12:0] off_next;
    logic signed [13:0] dur;
    logic signed [12:0] now13;
    logic            hit_on;
    logic            hit_off;
    logic            fire_next;
    logic [AW+3:0]   idx_ext;
    dos_pkg::res_t   res_next;

    // hold the whole walk while a firing entry waits for queue space
    assign adv   = !(s3_vld_reg && s3_fire_reg && !q_st.ready);
    assign issue = run_reg && adv && (cnt_reg != CW'(ENTRIES));
    assign rd_en   = adv;
    assign rd_addr = cnt_reg[AW-1:0];

    always_comb begin
        act_next = rd_valid && (rd_entry.kind inside {dos_pkg::KIND_ONE, dos_pkg::KIND_ALL});
        on_next  = to_utc(rd_entry.on_ref, rd_entry.on_ofs, ctx.loc_ofs, ctx.rise,
                          ctx.sun_set);
        off_next = to_utc(rd_entry.off_ref, rd_entry.off_ofs, ctx.loc_ofs, ctx.rise,
                          ctx.sun_set);
    end

    always_comb begin
        dur = {s2_off_reg[12], s2_off_reg} - {s2_on_reg[12], s2_on_reg};
        if (dur >= 14'sd1080) begin
            dur = dur - 14'sd1440;
        end
        if (dur < -14'sd360) begin
            dur = dur + 14'sd1440;
        end
        now13   = $signed({2'b00, ctx.now});
        hit_on  = (s2_on_reg == now13);
        hit_off = (s2_off_reg == now13);
        fire_next = s2_act_reg && (dur >= 14'sd1) && (hit_on || hit_off);
        idx_ext = {{4{1'b0}}, s2_idx_reg};
        res_next.entry_number = idx_ext[3:0];
        res_next.switch_on    = hit_on;
        res_next.all_rooms    = s2_all_reg;
        res_next.target_room  = s2_all_reg ? 8'd0 : s2_room_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= 1'b0;
            cnt_reg    <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
        end else begin
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end else if (issue) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ENTRIES - 1)) begin
                    run_reg <= 1'b0;
                end
            end
            if (adv) begin
                s1_vld_reg <= issue;
                s2_vld_reg <= s1_vld_reg;
                s3_vld_reg <= s2_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_idx_reg  <= rd_addr;
            s2_idx_reg  <= s1_idx_reg;
            s2_act_reg  <= act_next;
            s2_all_reg  <= (rd_entry.kind == dos_pkg::KIND_ALL);
            s2_room_reg <= rd_entry.room;
            s2_on_reg   <= on_next;
            s2_off_reg  <= off_next;
            s3_fire_reg <= fire_next;
            s3_res_reg  <= res_next;
        end
    end

    assign push    = s3_vld_reg && s3_fire_reg && q_st.ready;
    assign res     = s3_res_reg;
    assign st.busy = run_reg || s1_vld_reg || s2_vld_reg || s3_vld_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !st.busy)
        else $error("scan started while a walk is in progress");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        run_reg |-> (cnt_reg < CW'(ENTRIES)))
        else $error("walk counter passed the table depth");

endmodule
`default_nettype wire

// File: rtl/dos_result_q.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dos_result_q
// Result holding stage and output register. One command is held back so that
// the last one of a tick can be marked once the walk ends.
// ----------------------------------------------------------------------------
module dos_result_q (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   push,
    input  dos_pkg::res_t                         res,
    input  wire                                   flush,
    output dos_pkg::q_status_t                    q_st,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // [3:0] entry_number, [4] switch_on, [5] all_rooms, [13:6] target_room
    output logic [dos_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                  m_tlast
);

    logic          pend_vld_reg;
    dos_pkg::res_t pend_reg;
    logic          out_vld_reg;
    dos_pkg::res_t out_reg;
    logic          out_last_reg;
    logic          out_free;
    logic          load_out;
    logic          drain;

    assign out_free = !out_vld_reg || m_tready;
    assign drain    = flush && pend_vld_reg && out_free;
    assign load_out = (push && pend_vld_reg) || drain;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end else begin
            if (push) begin
                pend_vld_reg <= 1'b1;
            end else if (drain) begin
                pend_vld_reg <= 1'b0;
            end
            if (load_out) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            pend_reg <= res;
        end
        if (load_out) begin
            out_reg      <= pend_reg;
            out_last_reg <= flush;
        end
    end

    assign q_st.ready    = !pend_vld_reg || out_free;
    assign q_st.pend_vld = pend_vld_reg;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(dos_pkg::M_TDATA_W - 14){1'b0}}, out_reg.target_room,
                       out_reg.all_rooms, out_reg.switch_on, out_reg.entry_number};
    assign m_tlast  = out_last_reg;

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> q_st.ready)
        else $error("request pushed with no room");

    a_push_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && flush))
        else $error("push during end-of-tick flush");

endmodule
`default_nettype wire

// File: rtl/daily_on_off_schedule_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// daily_on_off_schedule_table
// Schedule table top level: request decode, offset registers, tick sequencer.
// ----------------------------------------------------------------------------
// Write request: written when taken, next request accepted the cycle after.
// Tick request on a new minute: walks ENTRIES entries at one read per cycle,
// held while a firing entry waits for queue space, through the entry memory
// read port; ready returns once the walk ends and the held command is in the output register.
// A repeated minute starts no walk. Synchronous reset: all entries empty,
// offsets 0 and 1 hour, no minute scanned yet. No clearing pass.
// ----------------------------------------------------------------------------
module daily_on_off_schedule_table #(
    parameter int ENTRIES = 16
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    input  wire                                   cfg_we,
    input  wire                                   cfg_index,
    input  wire [4:0]                             cfg_wdata,
    input  wire                                   s_tvalid,
    output logic                                  s_tready,
    // [3:0] entry_index, [5:4] entry_kind, [13:6] room_id, [16:14] on_reference,
    // [28:17] on_offset, [31:29] off_reference, [43:32] off_offset,
    // [54:44] minute_of_day, [55] daylight_saving, [66:56] sunrise_minute,
    // [77:67] sunset_minute
    input  wire [dos_pkg::S_TDATA_W-1:0]          s_tdata,
    // [0] func
    input  wire                                   s_tuser,
    output logic                                  m_tvalid,
    input  wire                                   m_tready,
    // [3:0] entry_number, [4] switch_on, [5] all_rooms, [13:6] target_room
    output logic [dos_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic                                  m_tlast
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic signed [4:0]  std_hours_reg;
    logic signed [4:0]  dst_hours_reg;
    logic [10:0]        last_min_reg;
    dos_pkg::tick_ctx_t ctx_reg;

    logic [3:0]         entry_index;
    dos_pkg::entry_t    wr_entry;
    logic [10:0]        minute_of_day;
    logic               daylight_saving;
    logic [10:0]        sunrise_minute;
    logic [10:0]        sunset_minute;

    logic               accept;
    logic               wr_req;
    logic               tick_req;
    logic               tick_new;
    logic [AW+3:0]      wr_idx_ext;
    logic signed [4:0]  hours_sel;
    logic signed [11:0] hours_ext;
    logic signed [11:0] loc_prod;

    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    dos_pkg::entry_t    rd_entry;
    logic               rd_valid;
    logic               push;
    dos_pkg::res_t      res;
    dos_pkg::q_status_t q_st;
    dos_pkg::scan_status_t scan_st;

    assign entry_index      = s_tdata[3:0];
    assign wr_entry.kind    = s_tdata[5:4];
    assign wr_entry.room    = s_tdata[13:6];
    assign wr_entry.on_ref  = s_tdata[16:14];
    assign wr_entry.on_ofs  = s_tdata[28:17];
    assign wr_entry.off_ref = s_tdata[31:29];
    assign wr_entry.off_ofs = s_tdata[43:32];
    assign minute_of_day    = s_tdata[54:44];
    assign daylight_saving  = s_tdata[55];
    assign sunrise_minute   = s_tdata[66:56];
    assign sunset_minute    = s_tdata[77:67];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign wr_req   = accept && (s_tuser == dos_pkg::FUNC_WRITE)
                      && (32'(entry_index) < ENTRIES);
    assign tick_req = accept && (s_tuser == dos_pkg::FUNC_TICK);
    assign tick_new = tick_req && (minute_of_day != last_min_reg);
    assign wr_idx_ext = {{AW{1'b0}}, entry_index};

    // hours * 60 as (h << 6) - (h << 2)
    assign hours_sel = daylight_saving ? dst_hours_reg : std_hours_reg;
    assign hours_ext = {{7{hours_sel[4]}}, hours_sel};
    assign loc_prod  = (hours_ext <<< 6) - (hours_ext <<< 2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            std_hours_reg <= 5'sd0;
            dst_hours_reg <= 5'sd1;
            last_min_reg  <= dos_pkg::MINUTE_NONE;
            state_reg     <= ST_IDLE;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    dos_pkg::CFG_STD_OFFSET: std_hours_reg <= cfg_wdata;
                    dos_pkg::CFG_DST_OFFSET: dst_hours_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (tick_new) begin
                last_min_reg <= minute_of_day;
            end
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_new) begin
            ctx_reg.now     <= minute_of_day;
            ctx_reg.loc_ofs <= loc_prod[10:0];
            ctx_reg.rise    <= sunrise_minute;
            ctx_reg.sun_set <= sunset_minute;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_new) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!scan_st.busy) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!q_st.pend_vld) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    dos_entry_mem #(
        .ENTRIES (ENTRIES),
        .AW      (AW)
    ) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (wr_req),
        .wr_addr  (wr_idx_ext[AW-1:0]),
        .wr_data  (wr_entry),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_entry),
        .rd_valid (rd_valid)
    );

    dos_scan #(
        .ENTRIES (ENTRIES),
        .AW      (AW),
        .CW      (CW)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (tick_new),
        .ctx      (ctx_reg),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .rd_valid (rd_valid),
        .q_st     (q_st),
        .push     (push),
        .res      (res),
        .st       (scan_st)
    );

    dos_result_q u_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .res      (res),
        .flush    (state_reg == ST_FLUSH),
        .q_st     (q_st),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (!scan_st.busy && !q_st.pend_vld))
        else $error("idle with a walk or held command outstanding");

    a_tick_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        tick_new |=> (state_reg == ST_SCAN) && scan_st.busy)
        else $error("new minute did not start a walk");

    a_repeat_minute: assert property (@(posedge aclk) disable iff (!aresetn)
        (tick_req && !tick_new) |=> (state_reg == ST_IDLE))
        else $error("repeated minute started a walk");

endmodule
`default_nettype wire

// File: dv/daily_on_off_schedule_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// daily_on_off_schedule_table_tb
// Self-checking bench for the on/off schedule table. A short directed table
// walks reset state, repeated and out-of-range minutes, unused kinds, invalid
// references, duration folding and multi-command ticks. Random phases follow
// under several offset settings, back-pressure on both streams after the first.
// Every command is checked field by field against a local model or typed row.
// ----------------------------------------------------------------------------
module daily_on_off_schedule_table_tb;
    import dos_pkg::*;

    localparam int ENTRIES       = 16;
    localparam int MAX_CMDS      = 16;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 64;
    localparam int SETTLE_CYCLES = ENTRIES + 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int LIMIT_CYCLES  = 1000000;
    localparam int MAX_PRINTS    = 40;

    localparam logic [2:0] REF_BAD    = 3'd4;   // first code with no meaning
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  pad;
        logic [10:0] sun_set;
        logic [10:0] sunrise;
        logic        dst;
        logic [10:0] minute;
        logic [11:0] off_ofs;
        logic [2:0]  off_ref;
        logic [11:0] on_ofs;
        logic [2:0]  on_ref;
        logic [7:0]  room;
        logic [1:0]  kind;
        logic [3:0]  index;
    } req_fields_t;

    typedef struct packed {
        logic        func;
        req_fields_t f;
    } sched_item_t;

    typedef struct packed {
        logic [3:0] entry_number;
        logic       switch_on;
        logic       all_rooms;
        logic [7:0] target_room;
        logic       last;
    } sched_cmd_t;

    typedef struct packed {
        sched_item_t it;
        logic        typed;     // expectation given below instead of from the model
        logic [1:0]  n_typed;
        sched_cmd_t  cmd;
    } dir_row_t;

    localparam sched_cmd_t NO_CMD = '0;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic                 cfg_index;
    logic [4:0]           cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // model of the table
    entry_t             sched_tab [ENTRIES];
    logic [10:0]        last_minute;
    logic signed [4:0]  std_hours;
    logic signed [4:0]  dst_hours;
    sched_cmd_t         pending_cmds[$];

    // random session context
    int   cur_min;
    int   sess_rise;
    int   sess_set;
    logic sess_dst;

    int   errors;
    int   cycles;
    int   items_sent;
    int   cmds_seen;
    int   hold_reqs;
    logic tx_idle;
    logic rx_idle;

    daily_on_off_schedule_table #(
        .ENTRIES (ENTRIES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("daily_on_off_schedule_table regression: fail");
        $finish;
    end

    task automatic report_error(input string msg);
        if (errors < MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    function automatic int utc_minute(input logic [2:0] sel, input logic signed [11:0] ofs,
                                      input logic dst, input int rise, input int sset);
        int r;
        int hrs;
        hrs = dst ? dst_hours : std_hours;
        case (sel)
            REF_UTC:   r = ofs;
            REF_LOCAL: begin
                r = ofs - 60 * hrs;
                if (r < 0)
                    r += 1440;       // single wrap only
            end
            REF_RISE:  r = ofs + rise;
            REF_SET:   r = ofs + sset;
            default:   r = -1;
        endcase
        return r;
    endfunction

    function automatic void predict_commands(input sched_item_t it, ref sched_cmd_t cmds[$]);
        int     now;
        int     on_t;
        int     off_t;
        int     d;
        logic   all;
        entry_t e;
        cmds.delete();
        if (it.func == FUNC_WRITE) begin
            sched_tab[it.f.index] = '{kind: it.f.kind, room: it.f.room,
                                      on_ref: it.f.on_ref, on_ofs: it.f.on_ofs,
                                      off_ref: it.f.off_ref, off_ofs: it.f.off_ofs};
            return;
        end
        if (it.f.minute == last_minute)
            return;
        last_minute = it.f.minute;
        now = it.f.minute;
        for (int i = 0; i < ENTRIES; i++) begin
            e = sched_tab[i];
            if (e.kind != KIND_ONE && e.kind != KIND_ALL)
                continue;
            on_t  = utc_minute(e.on_ref, e.on_ofs, it.f.dst, it.f.sunrise, it.f.sun_set);
            off_t = utc_minute(e.off_ref, e.off_ofs, it.f.dst, it.f.sunrise, it.f.sun_set);
            d = off_t - on_t;
            if (d >= 1080)
                d -= 1440;
            if (d < -360)
                d += 1440;
            if (d < 1)
                continue;
            all = (e.kind == KIND_ALL);
            if (on_t == now && cmds.size() < MAX_CMDS)
                cmds.push_back(sched_cmd_t'{i[3:0], 1'b1, all, all ? 8'd0 : e.room, 1'b0});
            if (off_t == now && cmds.size() < MAX_CMDS)
                cmds.push_back(sched_cmd_t'{i[3:0], 1'b0, all, all ? 8'd0 : e.room, 1'b0});
        end
        if (cmds.size() > 0)
            cmds[cmds.size() - 1].last = 1'b1;
    endfunction

    function automatic sched_item_t mk_write(input int idx, input logic [1:0] kind,
                                             input logic [7:0] room,
                                             input logic [2:0] on_sel, input int on_ofs,
                                             input logic [2:0] off_sel, input int off_ofs);
        sched_item_t it;
        it = {$urandom, $urandom, $urandom};   // tick fields are don't-care here
        it.func      = FUNC_WRITE;
        it.f.pad     = '0;
        it.f.index   = idx[3:0];
        it.f.kind    = kind;
        it.f.room    = room;
        it.f.on_ref  = on_sel;
        it.f.on_ofs  = on_ofs[11:0];
        it.f.off_ref = off_sel;
        it.f.off_ofs = off_ofs[11:0];
        return it;
    endfunction

    function automatic sched_item_t mk_tick(input int minute, input logic dst,
                                            input int rise, input int sset);
        sched_item_t it;
        it = {$urandom, $urandom, $urandom};
        it.func      = FUNC_TICK;
        it.f.pad     = '0;
        it.f.minute  = minute[10:0];
        it.f.dst     = dst;
        it.f.sunrise = rise[10:0];
        it.f.sun_set = sset[10:0];
        return it;
    endfunction

    function automatic logic [2:0] pick_ref();
        if ($urandom_range(0, 19) == 0)
            return REF_BAD + 3'($urandom_range(0, 3));
        return 3'($urandom_range(REF_UTC, REF_SET));
    endfunction

    function automatic logic [1:0] pick_kind();
        case ($urandom_range(0, 9))
            0:          return KIND_EMPTY;
            1:          return KIND_SPARE;
            2, 3, 4, 5: return KIND_ALL;
            default:    return KIND_ONE;
        endcase
    endfunction

    // offset that lands an entry time on a chosen UTC minute
    function automatic int ofs_for(input logic [2:0] sel, input int tgt);
        case (sel)
            REF_UTC:   return tgt;
            REF_LOCAL: return tgt + 60 * (sess_dst ? dst_hours : std_hours);
            REF_RISE:  return tgt - sess_rise;
            REF_SET:   return tgt - sess_set;
            default:   return int'($urandom_range(0, 4095)) - 2048;
        endcase
    endfunction

    function automatic sched_item_t random_item();
        sched_item_t it;
        int          pick;
        int          tgt;
        int          span;
        int          minute;
        logic [2:0]  on_sel;
        logic [2:0]  off_sel;
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            it = {$urandom, $urandom, $urandom};
            it.f.pad = '0;
            return it;
        end
        if (pick < 50) begin
            // entry aimed a few minutes ahead of the running clock
            on_sel  = pick_ref();
            off_sel = pick_ref();
            tgt  = (cur_min + $urandom_range(1, 12)) % 1440;
            span = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2000)
                                               : $urandom_range(1, 400);
            return mk_write($urandom_range(0, ENTRIES - 1), pick_kind(),
                            8'($urandom_range(0, 255)), on_sel, ofs_for(on_sel, tgt),
                            off_sel, ofs_for(off_sel, (tgt + span) % 1440));
        end
        if ($urandom_range(0, 19) == 0) begin
            sess_rise = $urandom_range(200, 600);
            sess_set  = $urandom_range(900, 1300);
        end
        if ($urandom_range(0, 29) == 0)
            sess_dst = ~sess_dst;
        case ($urandom_range(0, 19))
            0, 1:    ;                                  // same minute again
            2:       cur_min = $urandom_range(0, 1439);
            default: cur_min = (cur_min + $urandom_range(1, 3)) % 1440;
        endcase
        minute = ($urandom_range(0, 19) == 0) ? $urandom_range(1440, 2047) : cur_min;
        return mk_tick(minute, ($urandom_range(0, 9) == 0) ? ~sess_dst : sess_dst,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : sess_rise,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : sess_set);
    endfunction

    task automatic send_item(input sched_item_t it);
        int gap;
        gap = (tx_idle && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = it.func;
        s_tdata  = it.f;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain_and_settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        // a tick with no hits leaves no trace, so allow a full scan to finish
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_offsets(input logic signed [4:0] std_h, input logic signed [4:0] dst_h);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_index = CFG_STD_OFFSET;
        cfg_wdata = std_h;
        @(negedge aclk);
        cfg_index = CFG_DST_OFFSET;
        cfg_wdata = dst_h;
        @(negedge aclk);
        cfg_we    = 1'b0;
        std_hours = std_h;
        dst_hours = dst_h;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        int stall;
        int hold;
        int seen;
        stall = 0;
        hold  = 0;
        seen  = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (seen != hold_reqs) begin
                seen = hold_reqs;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_tready = 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
                if (rx_idle && $urandom_range(0, 99) < 25)
                    stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        sched_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                report_error($sformatf("command with none pending: tdata %h tlast %b",
                                       m_tdata, m_tlast));
            end else begin
                want = pending_cmds.pop_front();
                cmds_seen++;
                check_field("entry_number", m_tdata[3:0], want.entry_number);
                check_field("switch_on", m_tdata[4], want.switch_on);
                check_field("all_rooms", m_tdata[5], want.all_rooms);
                check_field("target_room", m_tdata[13:6], want.target_room);
                check_field("last", m_tlast, want.last);
            end
        end
    end

    initial begin
        sched_cmd_t        predicted[$];
        dir_row_t          dir_tab[$];
        logic signed [4:0] std_pick [3];
        logic signed [4:0] dst_pick [3];
        logic signed [4:0] std_h;
        logic signed [4:0] dst_h;
        int                n_directed;

        std_pick = '{-5'sd12, 5'sd14, 5'sd0};
        dst_pick = '{5'sd14, -5'sd12, 5'sd0};
        errors     = 0;
        items_sent = 0;
        cmds_seen  = 0;
        hold_reqs  = 0;
        tx_idle    = 1'b0;
        rx_idle    = 1'b0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_STD_OFFSET;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tuser    = FUNC_TICK;
        s_tdata    = '0;
        foreach (sched_tab[i])
            sched_tab[i] = '0;
        last_minute = MINUTE_NONE;
        std_hours   = 5'sd0;
        dst_hours   = 5'sd1;
        cur_min     = 0;
        sess_rise   = 360;
        sess_set    = 1100;
        sess_dst    = 1'b0;

        // directed table, offsets at reset values
        dir_tab.push_back(dir_row_t'{mk_tick(2047, 1'b0, 0, 0), 1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(0, 1'b0, 0, 0), 1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_write(0, KIND_ONE, 8'hFF, REF_UTC, 100, REF_UTC, 200),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(100, 1'b0, 0, 0), 1'b1, 2'd1,
                                     sched_cmd_t'{4'd0, 1'b1, 1'b0, 8'hFF, 1'b1}});
        dir_tab.push_back(dir_row_t'{mk_tick(100, 1'b0, 0, 0), 1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(200, 1'b0, 0, 0), 1'b1, 2'd1,
                                     sched_cmd_t'{4'd0, 1'b0, 1'b0, 8'hFF, 1'b1}});
        dir_tab.push_back(dir_row_t'{mk_write(15, KIND_ALL, 8'h5A, REF_LOCAL, 0, REF_LOCAL, 600),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(0, 1'b0, 0, 0), 1'b1, 2'd1,
                                     sched_cmd_t'{4'd15, 1'b1, 1'b1, 8'd0, 1'b1}});
        dir_tab.push_back(dir_row_t'{mk_tick(540, 1'b1, 0, 0), 1'b0, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_write(1, KIND_SPARE, 8'h01, REF_UTC, 300, REF_UTC, 400),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(300, 1'b0, 0, 0), 1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_write(2, KIND_ONE, 8'h00, 3'd7, 0, REF_UTC, 500),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(500, 1'b0, 0, 0), 1'b0, 2'd0, NO_CMD});
        // equal times: zero duration, never fires
        dir_tab.push_back(dir_row_t'{mk_write(3, KIND_ONE, 8'h3C, REF_UTC, 700, REF_UTC, 700),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(700, 1'b0, 0, 0), 1'b0, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_write(4, KIND_ONE, 8'hAA, REF_UTC, -2048, REF_UTC, 2047),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(2047, 1'b1, 2047, 2047), 1'b0, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_write(5, KIND_ALL, 8'h77, REF_RISE, -30, REF_SET, 45),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(330, 1'b0, 360, 1100), 1'b0, 2'd0, NO_CMD});
        // wrapped durations: one folds positive, one folds negative
        dir_tab.push_back(dir_row_t'{mk_write(6, KIND_ONE, 8'h12, REF_UTC, 1300, REF_UTC, 100),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_write(7, KIND_ONE, 8'h34, REF_UTC, 0, REF_UTC, 1200),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_write(8, KIND_ONE, 8'h81, REF_UTC, 1300, REF_UTC, 1400),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(1300, 1'b0, 360, 1100), 1'b0, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_write(9, KIND_ONE, 8'h00, REF_SET, 0, REF_BAD, 0),
                                     1'b1, 2'd0, NO_CMD});
        dir_tab.push_back(dir_row_t'{mk_tick(0, 1'b0, 360, 1100), 1'b0, 2'd0, NO_CMD});
        n_directed = dir_tab.size();

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_tab[k]) begin
            send_item(dir_tab[k].it);
            predict_commands(dir_tab[k].it, predicted);
            if (dir_tab[k].typed) begin
                for (int j = 0; j < dir_tab[k].n_typed; j++)
                    pending_cmds.push_back(dir_tab[k].cmd);
            end else begin
                pending_cmds = {pending_cmds, predicted};
            end
        end
        drain_and_settle();

        for (int p = 0; p < PHASES; p++) begin
            if (p < 3) begin
                std_h = std_pick[p];
                dst_h = dst_pick[p];
            end else begin
                std_h = 5'(int'($urandom_range(0, 26)) - 12);
                dst_h = 5'(int'($urandom_range(0, 26)) - 12);
            end
            write_offsets(std_h, dst_h);
            // first phase runs back to back on both streams
            tx_idle = (p != 0);
            rx_idle = (p != 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 2 && k == 16)
                    hold_reqs++;     // long receiver hold-off while requests keep coming
                send_item(random_item());
                predict_commands(dut_last_item(), predicted);
                pending_cmds = {pending_cmds, predicted};
            end
            drain_and_settle();
        end

        $display("covered %0d requests (%0d directed), %0d commands checked",
                 items_sent, n_directed, cmds_seen);
        $display("%0d offset settings incl. extremes, back-pressure and a long output hold-off",
                 PHASES + 1);
        if (errors == 0)
            $display("daily_on_off_schedule_table regression: pass");
        else
            $display("daily_on_off_schedule_table regression: fail");
        $finish;
    end

    // rebuilds the request last presented on the input stream
    function automatic sched_item_t dut_last_item();
        sched_item_t it;
        it.func = s_tuser;
        it.f    = s_tdata;
        return it;
    endfunction

endmodule
